FILE: hdl/cartesian_to_polar_macros.svh
// assertion macros used by the cartesian_to_polar top level
`ifndef CARTESIAN_TO_POLAR_MACROS_SVH
`define CARTESIAN_TO_POLAR_MACROS_SVH

// when ante holds at a clock edge, cons must hold at the same edge
`define C2P_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// bad must never hold at a clock edge
`define C2P_ASSERT_NEVER(label, bad, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(bad)) \
    else $error(msg);

`endif

FILE: hdl/c2p_pkg.sv
// shared types, constants and arctangent table for the cartesian to polar pipeline
package c2p_pkg;

  localparam int RAD_STEPS = 16;   // one root bit per step
  localparam int SQ_W      = 32;   // x*x + y*y and sqrt remainder
  localparam int CW        = 27;   // cordic x/y, coordinates scaled by 256
  localparam int ZW        = 25;   // cordic angle accumulator, degrees q16
  localparam int ATAN_W    = 22;
  localparam int RAD_W     = 16;
  localparam int ANG_W     = 17;   // degrees q8

  localparam logic [ZW-1:0] Q16_90  = 25'd5898240;
  localparam logic [ZW-1:0] Q16_180 = 25'd11796480;
  localparam logic [ZW-1:0] Q16_270 = 25'd17694720;
  localparam logic [ZW-1:0] Q16_360 = 25'd23592960;

  localparam logic [ANG_W-1:0] Q8_90  = 17'd23040;
  localparam logic [ANG_W-1:0] Q8_180 = 17'd46080;
  localparam logic [ANG_W-1:0] Q8_270 = 17'd69120;
  localparam logic [ANG_W-1:0] Q8_360 = 17'd92160;

  localparam logic [ZW:0] Q16_HALF_LSB = 26'd128;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic x_zero;
    logic y_zero;
  } flags_t;

  typedef struct packed {
    logic [SQ_W-1:0]      rem;
    logic [SQ_W-1:0]      root;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] cz;
    flags_t               flags;
  } stage_t;

  // atan(2^-idx) in degrees, q16
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/c2p_step.sv
// one pipeline step: a square root bit and/or a cordic micro-rotation
module c2p_step #(
  parameter int STEP          = 0,
  parameter int CORDIC_STAGES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            prev_valid,
  input  c2p_pkg::stage_t prev,
  output logic            valid,
  output c2p_pkg::stage_t data
);
  import c2p_pkg::*;

  localparam bit          DO_SQRT   = (STEP < RAD_STEPS);
  localparam bit          DO_CORDIC = (STEP < CORDIC_STAGES);
  localparam int          SQ_POS    = DO_SQRT ? 2 * (RAD_STEPS - 1 - STEP) : 0;
  localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << SQ_POS;
  localparam logic [4:0]  ATAN_IDX  = 5'(STEP);

  stage_t               nxt;
  logic [SQ_W-1:0]      trial;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] ang_step;

  always_comb begin
    nxt      = prev;
    trial    = prev.root + SQ_BIT;
    xs       = prev.cx >>> STEP;
    ys       = prev.cy >>> STEP;
    ang_step = $signed(ZW'(atan_q16(ATAN_IDX)));
    if (DO_SQRT) begin
      if (prev.rem >= trial) begin
        nxt.rem  = prev.rem - trial;
        nxt.root = (prev.root >> 1) + SQ_BIT;
      end else begin
        nxt.root = prev.root >> 1;
      end
    end
    if (DO_CORDIC) begin
      // rotate toward the x axis, direction from the sign of y
      if (!prev.cy[CW-1]) begin
        nxt.cx = prev.cx + ys;
        nxt.cy = prev.cy - xs;
        nxt.cz = prev.cz + ang_step;
      end else begin
        nxt.cx = prev.cx - ys;
        nxt.cy = prev.cy + xs;
        nxt.cz = prev.cz - ang_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= nxt;
    end
  end

endmodule

FILE: hdl/cartesian_to_polar.sv
// top level: pipelined cartesian to polar converter (sqrt radius, cordic angle)
// A point (x_coord, y_coord) enters on the point channel and its polar form
// leaves on the polar channel. radius is round(sqrt(x*x + y*y)), midpoints
// rounding up; angle_deg is degrees in [0, 360) with 8 fraction bits, exact
// on the axes (0, 90, 180, 270), and the origin gives origin_error = 1 with
// radius and angle zero. One point is accepted per clock while point_stall is
// low, and results leave in order, one beat per point, through a squaring
// stage, a sum stage, one stage per square root bit or cordic micro-rotation
// (both run side by side in the same steps), a finishing stage that rounds
// the radius and folds the angle into the point's quadrant, and the output
// register. Every stage has its own valid bit and moves when the stage after
// it is empty or moving, so bubbles close up under a stall on the polar side
// and a new beat can be taken while a finished result waits. CORDIC_STAGES
// (8 to 24) sets the number of micro-rotations and so the angle accuracy.
`include "cartesian_to_polar_macros.svh"

module cartesian_to_polar #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                point_valid,
  output logic                                point_stall,
  input  logic signed [15:0]                  x_coord,
  input  logic signed [15:0]                  y_coord,
  output logic                                polar_valid,
  input  logic                                polar_stall,
  output logic [c2p_pkg::RAD_W-1:0]           radius,
  output logic [c2p_pkg::ANG_W-1:0]           angle_deg,
  output logic                                origin_error
);
  import c2p_pkg::*;

  localparam int PIPE_STEPS = (CORDIC_STAGES > RAD_STEPS) ? CORDIC_STAGES : RAD_STEPS;

  // squaring stage
  logic                 pre_valid;
  logic [SQ_W-2:0]      pre_xsq;
  logic [SQ_W-2:0]      pre_ysq;
  logic signed [CW-1:0] pre_cx;
  logic signed [CW-1:0] pre_cy;
  flags_t               pre_flags;
  logic                 pre_adv;

  logic signed [SQ_W-1:0] x_prod;
  logic signed [SQ_W-1:0] y_prod;
  logic signed [CW-1:0]   x_ext;
  logic signed [CW-1:0]   y_ext;
  flags_t                 in_flags;

  // sum stage feeds st_data[0]; step i writes st_data[i+1]
  stage_t st_data  [PIPE_STEPS+1];
  logic   st_valid [PIPE_STEPS+1];
  logic   st_adv   [PIPE_STEPS+1];
  logic   sum_valid;
  stage_t sum_data;

  // finishing stage
  logic            fin_valid;
  logic [RAD_W-1:0] fin_radius;
  logic [ZW-1:0]   fin_total;
  flags_t          fin_flags;
  logic            fin_adv;
  logic            out_adv;

  stage_t           last;
  logic [RAD_W-1:0] root_lo;
  logic [RAD_W-1:0] rad_round;
  logic [ZW:0]      z_p180;
  logic [ZW:0]      z_p360;
  logic [ZW-1:0]    total;
  logic [ZW-1:0]    q_lo;
  logic [ZW-1:0]    q_hi;
  logic [ZW-1:0]    total_clamped;

  logic [ZW:0]      ang_sum;
  logic [ANG_W-1:0] ang_round;
  logic [ANG_W-1:0] ang_next;
  logic [RAD_W-1:0] radius_next;
  logic             origin_next;

  // ready chain, from the output back to the input
  assign out_adv = !polar_valid || !polar_stall;
  assign fin_adv = !fin_valid || out_adv;
  assign st_adv[PIPE_STEPS] = !st_valid[PIPE_STEPS] || fin_adv;
  for (genvar k = 0; k < PIPE_STEPS; k++) begin : g_adv
    assign st_adv[k] = !st_valid[k] || st_adv[k+1];
  end
  assign pre_adv     = !pre_valid || st_adv[0];
  assign point_stall = !pre_adv;

  // squares and cordic start: fold left half plane onto the right
  always_comb begin
    x_prod          = x_coord * x_coord;
    y_prod          = y_coord * y_coord;
    x_ext           = CW'(x_coord);
    y_ext           = CW'(y_coord);
    in_flags.xneg   = x_coord[15];
    in_flags.yneg   = y_coord[15];
    in_flags.x_zero = (x_coord == '0);
    in_flags.y_zero = (y_coord == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid <= 1'b0;
    end else if (pre_adv) begin
      pre_valid <= point_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pre_adv) begin
      pre_xsq   <= x_prod[SQ_W-2:0];
      pre_ysq   <= y_prod[SQ_W-2:0];
      pre_cx    <= (in_flags.xneg ? -x_ext : x_ext) <<< 8;
      pre_cy    <= (in_flags.xneg ? -y_ext : y_ext) <<< 8;
      pre_flags <= in_flags;
    end
  end

  // sum of squares seeds the remainder; root and angle accumulator start at zero
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (st_adv[0]) begin
      sum_valid <= pre_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st_adv[0]) begin
      sum_data.rem   <= {1'b0, pre_xsq} + {1'b0, pre_ysq};
      sum_data.root  <= '0;
      sum_data.cx    <= pre_cx;
      sum_data.cy    <= pre_cy;
      sum_data.cz    <= '0;
      sum_data.flags <= pre_flags;
    end
  end

  assign st_valid[0] = sum_valid;
  assign st_data[0]  = sum_data;

  for (genvar i = 0; i < PIPE_STEPS; i++) begin : g_step
    c2p_step #(
      .STEP          (i),
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_step (
      .clk        (clk),
      .rst        (rst),
      .en         (st_adv[i+1]),
      .prev_valid (st_valid[i]),
      .prev       (st_data[i]),
      .valid      (st_valid[i+1]),
      .data       (st_data[i+1])
    );
  end

  // radius rounding, angle unwrap and quadrant clamp
  always_comb begin
    last      = st_data[PIPE_STEPS];
    root_lo   = last.root[RAD_W-1:0];
    rad_round = (last.rem > SQ_W'(root_lo)) ? root_lo + 1'b1 : root_lo;
    z_p180    = $unsigned($signed({last.cz[ZW-1], last.cz}) + $signed({1'b0, Q16_180}));
    z_p360    = $unsigned($signed({last.cz[ZW-1], last.cz}) + $signed({1'b0, Q16_360}));
    // left half plane: add 180; right half plane below zero: wrap by 360
    if (last.flags.xneg) begin
      total = z_p180[ZW-1:0];
    end else if (last.cz[ZW-1]) begin
      total = z_p360[ZW-1:0];
    end else begin
      total = last.cz;
    end
    unique case ({last.flags.xneg, last.flags.yneg})
      2'b00: begin q_lo = '0;      q_hi = Q16_90;  end
      2'b10: begin q_lo = Q16_90;  q_hi = Q16_180; end
      2'b11: begin q_lo = Q16_180; q_hi = Q16_270; end
      default: begin q_lo = Q16_270; q_hi = Q16_360 - 1'b1; end
    endcase
    if (total < q_lo) begin
      total_clamped = q_lo;
    end else if (total > q_hi) begin
      total_clamped = q_hi;
    end else begin
      total_clamped = total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_adv) begin
      fin_valid <= st_valid[PIPE_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_adv) begin
      fin_radius <= rad_round;
      fin_total  <= total_clamped;
      fin_flags  <= last.flags;
    end
  end

  // angle to q8 with half-up rounding, axis cases and the origin
  always_comb begin
    ang_sum     = {1'b0, fin_total} + Q16_HALF_LSB;
    ang_round   = ANG_W'(ang_sum >> 8);
    origin_next = fin_flags.x_zero && fin_flags.y_zero;
    radius_next = fin_radius;
    priority if (origin_next) begin
      ang_next    = '0;
      radius_next = '0;
    end else if (fin_flags.y_zero) begin
      ang_next = fin_flags.xneg ? Q8_180 : '0;
    end else if (fin_flags.x_zero) begin
      ang_next = fin_flags.yneg ? Q8_270 : Q8_90;
    end else if (ang_round >= Q8_360) begin
      ang_next = '0;   // full turn reads as zero
    end else begin
      ang_next = ang_round;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      polar_valid <= 1'b0;
    end else if (out_adv) begin
      polar_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      radius       <= radius_next;
      angle_deg    <= ang_next;
      origin_error <= origin_next;
    end
  end

  `C2P_ASSERT_NEVER(origin_outputs_zero,
    polar_valid && origin_error && (radius != '0 || angle_deg != '0),
    "origin beat carries nonzero radius or angle")
  `C2P_ASSERT_IMP(angle_below_full_turn, polar_valid, angle_deg < Q8_360,
    "angle at or above 360 degrees")
  `C2P_ASSERT_IMP(radius_nonzero_off_origin, polar_valid && !origin_error, radius != '0,
    "zero radius for a point off the origin")
  `C2P_ASSERT_IMP(stall_only_when_full, point_stall, pre_valid && st_valid[0],
    "input stalled with a free slot behind the squaring stage")

endmodule
